FILE: rtl/core/two_resource_fit_allocator_unit_macros.svh
// assertion helpers shared by the allocator modules
// both sample on aclk and are masked while aresetn is low
`ifndef TWO_RESOURCE_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define TWO_RESOURCE_FIT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define TRFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/trfa_pkg.sv
package trfa_pkg;

    // fixed field widths of the item and result channels
    localparam int CORES_W  = 5;
    localparam int MEMORY_W = 7;
    localparam int NODE_W   = 7;
    localparam int STATUS_W = 2;
    localparam int POLICY_W = 2;

    // item kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // register index decoded from paddr
    localparam logic REG_FIT_POLICY = 1'b0;

    // node choice policy (code 3 behaves as first fit)
    typedef enum logic [POLICY_W-1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2
    } trfa_policy_e;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        STATUS_GRANTED  = 2'd0,
        STATUS_NOFIT    = 2'd1,
        STATUS_RELEASED = 2'd2
    } trfa_status_e;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REL_RD,
        ST_FINISH
    } trfa_state_e;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic addr_clr;
        logic addr_inc;
        logic clear_wr;
        logic scan_rd;
        logic tgt_rd;
        logic commit;
    } trfa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic addr_last;
    } trfa_stat_t;

endpackage

FILE: rtl/core/trfa_ctrl.sv
`include "two_resource_fit_allocator_unit_macros.svh"

module trfa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_kind,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  trfa_pkg::trfa_stat_t stat,
    output trfa_pkg::trfa_cmd_t  cmd
);
    import trfa_pkg::*;

    trfa_state_e state_reg;
    trfa_state_e state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;
    logic        in_xfer;

    assign out_free = !m_valid_reg || m_ready;
    assign in_xfer  = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // state and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_kind == KIND_RELEASE) ? ST_REL_RD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.addr_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_REL_RD: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.addr_inc = !stat.addr_last;
                cmd.addr_clr = stat.addr_last;
            end
            ST_IDLE: begin
                cmd.load_item = in_xfer;
            end
            ST_SCAN: begin
                cmd.scan_rd  = 1'b1;
                cmd.addr_inc = !stat.addr_last;
                cmd.addr_clr = stat.addr_last;
            end
            ST_REL_RD: begin
                cmd.tgt_rd = 1'b1;
            end
            ST_FINISH: begin
                cmd.commit = out_free;
            end
            default: cmd = '0;
        endcase
    end

    // result valid: set by a commit, dropped once the transfer completes
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `TRFA_ASSERT_NEXT(a_one_item, in_xfer, !s_ready, "item taken while another is in flight")
    `TRFA_ASSERT_NOW(a_no_overwrite, cmd.commit, out_free, "pending result overwritten")
    `TRFA_ASSERT_NEXT(a_commit_shows, cmd.commit, m_valid_reg, "committed result not presented")

endmodule

FILE: rtl/core/trfa_datapath.sv
`include "two_resource_fit_allocator_unit_macros.svh"

module trfa_datapath #(
    parameter int NODE_COUNT  = 128,
    parameter int NODE_CORES  = 24,
    parameter int NODE_MEMORY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  trfa_pkg::trfa_cmd_t           cmd,
    output trfa_pkg::trfa_stat_t          stat,
    input  logic [trfa_pkg::POLICY_W-1:0] fit_policy,
    input  logic                          s_kind,
    input  logic [trfa_pkg::CORES_W-1:0]  s_request_cores,
    input  logic [trfa_pkg::MEMORY_W-1:0] s_request_memory,
    input  logic [trfa_pkg::NODE_W-1:0]   s_target_node,
    output logic [trfa_pkg::STATUS_W-1:0] m_status,
    output logic [trfa_pkg::NODE_W-1:0]   m_chosen_node,
    output logic [trfa_pkg::CORES_W-1:0]  m_left_cores,
    output logic [trfa_pkg::MEMORY_W-1:0] m_left_memory
);
    import trfa_pkg::*;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int CORE_W = $clog2(NODE_CORES + 1);
    localparam int MEM_W  = $clog2(NODE_MEMORY + 1);
    localparam int WORD_W = CORE_W + MEM_W;
    localparam int CMP_CW = (CORE_W > CORES_W) ? CORE_W : CORES_W;
    localparam int CMP_MW = (MEM_W > MEMORY_W) ? MEM_W : MEMORY_W;
    localparam int TGT_W  = (IDX_W > NODE_W) ? IDX_W : NODE_W;

    // node table: free cores over free memory
    logic [WORD_W-1:0] node_mem [NODE_COUNT];

    logic                kind_reg;
    logic [CORES_W-1:0]  req_cores_reg;
    logic [MEMORY_W-1:0] req_mem_reg;
    logic [NODE_W-1:0]   target_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [IDX_W-1:0]    addr_next;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic [CORE_W-1:0]   best_cores_reg;
    logic [MEM_W-1:0]    best_mem_reg;
    logic [WORD_W-1:0]   rd_data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [CORES_W-1:0]  left_cores_reg;
    logic [MEMORY_W-1:0] left_mem_reg;

    logic [CORE_W-1:0]   rd_cores;
    logic [MEM_W-1:0]    rd_mem;
    logic [CMP_CW-1:0]   req_cores_w;
    logic [CMP_MW-1:0]   req_mem_w;
    logic                fits;
    logic                take;
    logic [IDX_W-1:0]    rd_addr;
    logic                rd_en;
    logic [TGT_W-1:0]    tgt_wide;
    logic [TGT_W-1:0]    pick_wide;
    logic [IDX_W-1:0]    tgt_idx;
    logic                tgt_ok;
    logic [CMP_CW-1:0]   alloc_cores;
    logic [CMP_MW-1:0]   alloc_mem;
    logic [CMP_CW:0]     sum_cores;
    logic [CMP_MW:0]     sum_mem;
    logic [CMP_CW:0]     sat_cores;
    logic [CMP_MW:0]     sat_mem;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [STATUS_W-1:0] status_next;
    logic [NODE_W-1:0]   node_next;
    logic [CORES_W-1:0]  left_cores_next;
    logic [MEMORY_W-1:0] left_mem_next;

    assign stat.addr_last = (addr_reg == IDX_W'(NODE_COUNT - 1));

    // sweep counter for clearing and scanning
    always_comb begin
        addr_next = addr_reg;
        if (cmd.addr_clr) begin
            addr_next = '0;
        end else if (cmd.addr_inc) begin
            addr_next = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            addr_reg    <= addr_next;
            cmp_vld_reg <= cmd.scan_rd;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg      <= s_kind;
            req_cores_reg <= s_request_cores;
            req_mem_reg   <= s_request_memory;
            target_reg    <= s_target_node;
        end
    end

    // release target decode
    assign tgt_wide  = TGT_W'(target_reg);
    assign tgt_idx   = tgt_wide[IDX_W-1:0];
    assign tgt_ok    = ((TGT_W + 1)'(target_reg) < (TGT_W + 1)'(NODE_COUNT));
    assign pick_wide = TGT_W'(pick_reg);

    // table read port
    assign rd_en   = cmd.scan_rd || cmd.tgt_rd;
    assign rd_addr = cmd.scan_rd ? addr_reg : tgt_idx;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= node_mem[rd_addr];
        end
        cmp_idx_reg <= addr_reg;
    end

    assign rd_cores    = rd_data_reg[WORD_W-1:MEM_W];
    assign rd_mem      = rd_data_reg[MEM_W-1:0];
    assign req_cores_w = CMP_CW'(req_cores_reg);
    assign req_mem_w   = CMP_MW'(req_mem_reg);

    // fit test and policy compare for the entry just read
    always_comb begin
        fits = cmp_vld_reg && (CMP_CW'(rd_cores) >= req_cores_w)
            && (CMP_MW'(rd_mem) >= req_mem_w);
        take = 1'b0;
        if (fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (fit_policy == POLICY_BEST) begin
                take = (rd_cores < best_cores_reg);
            end else if (fit_policy == POLICY_WORST) begin
                take = (rd_cores > best_cores_reg);
            end
        end
    end

    // best candidate so far
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load_item) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pick_reg       <= cmp_idx_reg;
            best_cores_reg <= rd_cores;
            best_mem_reg   <= rd_mem;
        end
    end

    // deduction for a grant, saturating return for a release
    always_comb begin
        alloc_cores = CMP_CW'(best_cores_reg) - req_cores_w;
        alloc_mem   = CMP_MW'(best_mem_reg) - req_mem_w;
        sum_cores   = (CMP_CW + 1)'(rd_cores) + (CMP_CW + 1)'(req_cores_reg);
        sum_mem     = (CMP_MW + 1)'(rd_mem) + (CMP_MW + 1)'(req_mem_reg);
        sat_cores   = (sum_cores > (CMP_CW + 1)'(NODE_CORES))
            ? (CMP_CW + 1)'(NODE_CORES) : sum_cores;
        sat_mem     = (sum_mem > (CMP_MW + 1)'(NODE_MEMORY))
            ? (CMP_MW + 1)'(NODE_MEMORY) : sum_mem;
    end

    // table write port and result fields
    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = {CORE_W'(NODE_CORES), MEM_W'(NODE_MEMORY)};
        status_next     = STATUS_NOFIT;
        node_next       = '0;
        left_cores_next = '0;
        left_mem_next   = '0;
        if (cmd.clear_wr) begin
            wr_en = 1'b1;
        end else if (cmd.commit) begin
            if (kind_reg == KIND_RELEASE) begin
                status_next = STATUS_RELEASED;
                node_next   = target_reg;
                if (tgt_ok) begin
                    wr_en           = 1'b1;
                    wr_addr         = tgt_idx;
                    wr_data         = {sat_cores[CORE_W-1:0], sat_mem[MEM_W-1:0]};
                    left_cores_next = sat_cores[CORES_W-1:0];
                    left_mem_next   = sat_mem[MEMORY_W-1:0];
                end
            end else if (found_reg) begin
                wr_en           = 1'b1;
                wr_addr         = pick_reg;
                wr_data         = {alloc_cores[CORE_W-1:0], alloc_mem[MEM_W-1:0]};
                status_next     = STATUS_GRANTED;
                node_next       = pick_wide[NODE_W-1:0];
                left_cores_next = alloc_cores[CORES_W-1:0];
                left_mem_next   = alloc_mem[MEMORY_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg     <= status_next;
            node_reg       <= node_next;
            left_cores_reg <= left_cores_next;
            left_mem_reg   <= left_mem_next;
        end
    end

    assign m_status      = status_reg;
    assign m_chosen_node = node_reg;
    assign m_left_cores  = left_cores_reg;
    assign m_left_memory = left_mem_reg;

    `TRFA_ASSERT_NOW(a_pick_covers, found_reg && !cmd.load_item, (CMP_CW'(best_cores_reg) >= req_cores_w) && (CMP_MW'(best_mem_reg) >= req_mem_w), "chosen node does not cover request")
    `TRFA_ASSERT_NOW(a_pick_range, found_reg, (TGT_W + 1)'(pick_reg) < (TGT_W + 1)'(NODE_COUNT), "chosen node beyond table")
    `TRFA_ASSERT_NEXT(a_scan_order, cmd.scan_rd, cmp_vld_reg && (cmp_idx_reg == $past(addr_reg)), "compare out of step with read")

endmodule

FILE: rtl/core/two_resource_fit_allocator_unit.sv
// Fit allocator over a table of NODE_COUNT worker nodes, each holding free cores and free
// memory. An allocate item scans every node once, one table entry per clock from a single
// read port, and grants the node picked by fit_policy (first fit, fewest free cores, most
// free cores; ties to the lowest index), deducting the request; a release item adds back
// to the named node, saturating at NODE_CORES and NODE_MEMORY. From one input transfer to
// the earliest next one an allocate goes through the scan reads, a compare step, a commit step
// and the idle state that takes the next item; a release goes through target read, commit
// and idle. The commit waits while an earlier result is still held by m_ready. One item is
// in work at a time; the result register lets the next item be taken while a result waits.
// After reset the whole table is filled before any item is taken; fit_policy at APB
// offset 0 is to be written only while no item is in work.
module two_resource_fit_allocator_unit #(
    parameter int NODE_COUNT  = 128,
    parameter int NODE_CORES  = 24,
    parameter int NODE_MEMORY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // item channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [trfa_pkg::CORES_W-1:0]  s_request_cores,
    input  logic [trfa_pkg::MEMORY_W-1:0] s_request_memory,
    input  logic [trfa_pkg::NODE_W-1:0]   s_target_node,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [trfa_pkg::STATUS_W-1:0] m_status,
    output logic [trfa_pkg::NODE_W-1:0]   m_chosen_node,
    output logic [trfa_pkg::CORES_W-1:0]  m_left_cores,
    output logic [trfa_pkg::MEMORY_W-1:0] m_left_memory
);
    import trfa_pkg::*;

    logic [POLICY_W-1:0] fit_policy_reg;
    logic                cfg_wr;
    trfa_cmd_t           cmd;
    trfa_stat_t          stat;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FIT_POLICY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= POLICY_FIRST;
        end else if (cfg_wr) begin
            fit_policy_reg <= pwdata[POLICY_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FIT_POLICY) ? 32'(fit_policy_reg) : '0;

    // sequencing
    trfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // node table and fit search
    trfa_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .NODE_CORES  (NODE_CORES),
        .NODE_MEMORY (NODE_MEMORY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .fit_policy       (fit_policy_reg),
        .s_kind           (s_kind),
        .s_request_cores  (s_request_cores),
        .s_request_memory (s_request_memory),
        .s_target_node    (s_target_node),
        .m_status         (m_status),
        .m_chosen_node    (m_chosen_node),
        .m_left_cores     (m_left_cores),
        .m_left_memory    (m_left_memory)
    );

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trfa_pkg::*;

    localparam int NODE_COUNT  = 128;
    localparam int NODE_CORES  = 24;
    localparam int NODE_MEMORY = 64;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int PHASE_COUNT = 7;
    localparam int REPORT_LIMIT = 10;
    // unused policy code, the block treats it as first fit
    localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [CORES_W-1:0]  cores;
        logic [MEMORY_W-1:0] memory;
        logic [NODE_W-1:0]   node;
    } alloc_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   node;
        logic [CORES_W-1:0]  cores;
        logic [MEMORY_W-1:0] memory;
    } alloc_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_kind = 1'b0;
    logic [CORES_W-1:0]  s_request_cores = '0;
    logic [MEMORY_W-1:0] s_request_memory = '0;
    logic [NODE_W-1:0]   s_target_node = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [NODE_W-1:0]   m_chosen_node;
    logic [CORES_W-1:0]  m_left_cores;
    logic [MEMORY_W-1:0] m_left_memory;

    // shadow of the node table and the policy register
    logic [CORES_W-1:0]  free_cores [NODE_COUNT];
    logic [MEMORY_W-1:0] free_memory [NODE_COUNT];
    logic [POLICY_W-1:0] fit_mode;

    alloc_item_t   pending_items [$];
    alloc_result_t awaited_results [$];
    alloc_item_t   next_item;
    alloc_result_t got_result;
    alloc_result_t want_result;
    int            fault_count = 0;
    bit            gap_free = 1'b0;

    two_resource_fit_allocator_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_request_cores  (s_request_cores),
        .s_request_memory (s_request_memory),
        .s_target_node    (s_target_node),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_chosen_node    (m_chosen_node),
        .m_left_cores     (m_left_cores),
        .m_left_memory    (m_left_memory)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // update the shadow table for one item and queue the result it should give
    task automatic account_item(input logic kind, input logic [CORES_W-1:0] cores,
                                input logic [MEMORY_W-1:0] memory,
                                input logic [NODE_W-1:0] node);
        alloc_result_t res;
        int            core_sum;
        int            mem_sum;
        int            pick;
        int            i;
        bit            found;
        if (kind == KIND_RELEASE) begin
            core_sum = free_cores[node] + cores;
            mem_sum = free_memory[node] + memory;
            if (core_sum > NODE_CORES) core_sum = NODE_CORES;
            if (mem_sum > NODE_MEMORY) mem_sum = NODE_MEMORY;
            free_cores[node] = CORES_W'(core_sum);
            free_memory[node] = MEMORY_W'(mem_sum);
            res.status = STATUS_RELEASED;
            res.node = node;
            res.cores = free_cores[node];
            res.memory = free_memory[node];
        end else begin
            found = 1'b0;
            pick = 0;
            for (i = 0; i < NODE_COUNT; i++) begin
                if (free_cores[i] >= cores && free_memory[i] >= memory) begin
                    if (!found) begin
                        found = 1'b1;
                        pick = i;
                        if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST) break;
                    end else if (fit_mode == POLICY_BEST
                                 && free_cores[i] < free_cores[pick]) begin
                        pick = i;
                    end else if (fit_mode == POLICY_WORST
                                 && free_cores[i] > free_cores[pick]) begin
                        pick = i;
                    end
                end
            end
            if (found) begin
                free_cores[pick] = free_cores[pick] - cores;
                free_memory[pick] = free_memory[pick] - memory;
                res.status = STATUS_GRANTED;
                res.node = NODE_W'(pick);
                res.cores = free_cores[pick];
                res.memory = free_memory[pick];
            end else begin
                res = '0;
                res.status = STATUS_NOFIT;
            end
        end
        awaited_results.insert(awaited_results.size(), res);
    endtask

    // item driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                account_item(s_kind, s_request_cores, s_request_memory, s_target_node);
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && (gap_free || $urandom_range(99) >= 8)) begin
                    next_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= next_item.kind;
                    s_request_cores <= next_item.cores;
                    s_request_memory <= next_item.memory;
                    s_target_node <= next_item.node;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_result = {m_status, m_chosen_node, m_left_cores, m_left_memory};
                if (awaited_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result transfer with none awaited: status %0d node %0d",
                                 m_status, m_chosen_node);
                end else begin
                    want_result = awaited_results.pop_front();
                    if (got_result != want_result) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display({"mismatch: expected st %0d node %0d cores %0d mem %0d,",
                                      " got st %0d node %0d cores %0d mem %0d"},
                                     want_result.status, want_result.node, want_result.cores,
                                     want_result.memory, got_result.status, got_result.node,
                                     got_result.cores, got_result.memory);
                    end
                end
            end
            m_ready <= gap_free || $urandom_range(99) >= 8;
        end
    end

    task automatic push_item(input logic kind, input int cores, input int memory,
                             input int node);
        alloc_item_t it;
        it.kind = kind;
        it.cores = CORES_W'(cores);
        it.memory = MEMORY_W'(memory);
        it.node = NODE_W'(node);
        pending_items.insert(pending_items.size(), it);
    endtask

    // random item, releases mostly aimed at nodes that hold something
    task automatic queue_random_item(input int alloc_pct);
        int roll;
        int start;
        int idx;
        int k;
        roll = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
            if (roll < 85)
                push_item(KIND_ALLOC, $urandom_range(12), $urandom_range(32),
                          $urandom_range(127));
            else if (roll < 95)
                push_item(KIND_ALLOC, $urandom_range(NODE_CORES), $urandom_range(NODE_MEMORY),
                          $urandom_range(127));
            else
                push_item(KIND_ALLOC, $urandom_range(31), $urandom_range(127),
                          $urandom_range(127));
        end else begin
            idx = $urandom_range(NODE_COUNT - 1);
            if ($urandom_range(99) < 75) begin
                start = idx;
                for (k = 0; k < NODE_COUNT; k++) begin
                    idx = (start + k) % NODE_COUNT;
                    if (free_cores[idx] < NODE_CORES || free_memory[idx] < NODE_MEMORY) break;
                end
            end
            if (roll < 90)
                push_item(KIND_RELEASE, $urandom_range(12), $urandom_range(32), idx);
            else
                push_item(KIND_RELEASE, $urandom_range(31), $urandom_range(127), idx);
        end
    endtask

    // wait for the block to go quiet
    task automatic wait_drained;
        while (pending_items.size() != 0 || s_valid || awaited_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_policy(input logic [POLICY_W-1:0] code);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_FIT_POLICY, 2'b00};
        pwdata <= 32'(code);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fit_mode = code;
    endtask

    // stimulus: directed start, then random phases under each policy
    initial begin
        logic [POLICY_W-1:0] phase_policy [PHASE_COUNT];
        int                  phase;
        int                  n;
        int                  alloc_pct;
        phase_policy = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_SPARE,
                         POLICY_FIRST, POLICY_WORST, POLICY_BEST};
        for (n = 0; n < NODE_COUNT; n++) begin
            free_cores[n] = CORES_W'(NODE_CORES);
            free_memory[n] = MEMORY_W'(NODE_MEMORY);
        end
        fit_mode = POLICY_FIRST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            write_policy(phase_policy[phase]);
            gap_free = (phase == 4);
            if (phase == 0) begin
                // zero request, oversized requests, exact capacity, saturation
                push_item(KIND_ALLOC, 0, 0, 0);
                push_item(KIND_ALLOC, 31, 0, 0);
                push_item(KIND_ALLOC, 0, 127, 0);
                push_item(KIND_ALLOC, 31, 127, 127);
                push_item(KIND_ALLOC, NODE_CORES, NODE_MEMORY, 0);
                push_item(KIND_ALLOC, 1, 1, 127);
                push_item(KIND_ALLOC, NODE_CORES + 1, 1, 0);
                push_item(KIND_ALLOC, 1, NODE_MEMORY + 1, 0);
                push_item(KIND_RELEASE, 31, 127, 0);
                push_item(KIND_RELEASE, 0, 0, 127);
                push_item(KIND_RELEASE, 31, 127, 127);
                push_item(KIND_RELEASE, 5, 5, 1);
                push_item(KIND_ALLOC, NODE_CORES, 0, 85);
                push_item(KIND_ALLOC, 0, NODE_MEMORY, 42);
                push_item(KIND_ALLOC, 1, 1, 0);
                push_item(KIND_RELEASE, 16, 32, 0);
                push_item(KIND_ALLOC, 20, 10, 0);
                push_item(KIND_ALLOC, 10, 60, 0);
                push_item(KIND_RELEASE, 0, 0, 0);
                push_item(KIND_RELEASE, 31, 127, 1);
            end
            alloc_pct = 55;
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    case ($urandom_range(2))
                        0: begin
                            alloc_pct = 30;
                        end
                        1: begin
                            alloc_pct = 55;
                        end
                        default: begin
                            alloc_pct = 75;
                        end
                    endcase
                end
                @(negedge aclk);
                while (pending_items.size() >= 2) @(negedge aclk);
                queue_random_item(alloc_pct);
            end
            wait_drained();
        end

        gap_free = 1'b0;
        repeat (20) @(posedge aclk);
        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
